### sv/assert_macros.svh
// Assertion macros used by the checker file brl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is disabled while reset is active.
`define BRL_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("byte range lock assertion failed");

// Concurrent assertion that is checked during reset too.
`define BRL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("byte range lock assertion failed");

`endif

### sv/brl_pkg.sv
`default_nettype none
package brl_pkg;

    // Command codes on the request channel.
    localparam logic [1:0] CMD_LOCK    = 2'd0;
    localparam logic [1:0] CMD_UNLOCK  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Status codes on the response channel.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_WRAP       = 3'd1;
    localparam logic [2:0] ST_CONFLICT   = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_NOT_LOCKED = 3'd4;

    // Operations after classification in the front end.
    localparam logic [2:0] OP_LOCK    = 3'd0;
    localparam logic [2:0] OP_UNLOCK  = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_NOP     = 3'd3;
    localparam logic [2:0] OP_WRAP    = 3'd4;

    // One classified request as it travels through the queue.
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  file_id;
        logic [15:0] owner_id;
        logic [63:0] range_offset;
        logic [63:0] range_length;
        logic [63:0] range_end;
        logic        want_exclusive;
    } t_job;

    // One stored lock entry.
    typedef struct packed {
        logic [7:0]  file_id;
        logic [15:0] owner_id;
        logic [63:0] range_offset;
        logic [63:0] range_length;
        logic        exclusive;
    } t_slot;

endpackage
`default_nettype wire

### sv/brl_if.sv
`default_nettype none
// Request channel: one lock, unlock or release command per beat.
interface brl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  file_id;
    logic [15:0] owner_id;
    logic [63:0] range_offset;
    logic [63:0] range_length;
    logic        want_exclusive;

    modport source (output valid, cmd, file_id, owner_id, range_offset, range_length,
                    want_exclusive, input ready);
    modport sink (input valid, cmd, file_id, owner_id, range_offset, range_length,
                  want_exclusive, output ready);
endinterface

// Response channel: one status per beat.
interface brl_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface
`default_nettype wire

### sv/byte_range_lock_table_unit.sv
// Byte-range lock table.
// Requests arrive on i_req (cmd, file, owner, offset, length, exclusive flag)
// and each produces exactly one status beat on o_rsp, in request order.
// A front end classifies each request (wrap check, command decode) and puts
// it in a two-entry queue; a back end walks the lock table, held in RAM, one
// slot per cycle through a registered read port.
// Lock, unlock and release walk the table slot by slot up to the last slot;
// unlock and lock conflicts may end the walk early. A wrapping lock or an
// unused command skips the walk and answers straight from the done state.
// Throughput is one request per walk, set by the single table read port.
// After reset the back end first clears every slot of the valid memory;
// requests are queued meanwhile and served afterwards.
// If the receiver stalls o_rsp, the status is held in the output register;
// the back end can finish one more request and then waits, and the queue
// keeps accepting until it is full, after which i_req.ready drops.
`default_nettype none
module byte_range_lock_table_unit
    import brl_pkg::*;
#(
    parameter int LOCK_SLOTS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    brl_req_if.sink    i_req,
    brl_rsp_if.source  o_rsp
);
    logic push, full, pop, q_valid;
    t_job push_job, q_job;

    // Request classification.
    brl_front u_front (
        .i_req  (i_req),
        .o_push (push),
        .o_job  (push_job),
        .i_full (full)
    );

    // Decoupling queue.
    brl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Table walk and update.
    brl_back #(.LOCK_SLOTS(LOCK_SLOTS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );
endmodule
`default_nettype wire

### sv/brl_ram.sv
`default_nettype none
module brl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### sv/brl_front.sv
`default_nettype none
module brl_front
    import brl_pkg::*;
(
    brl_req_if.sink    i_req,
    output logic       o_push,
    output t_job       o_job,
    input  wire logic  i_full
);
    logic [64:0] sum;

    // The end of the range, with its carry for the wrap check.
    assign sum = {1'b0, i_req.range_offset} + {1'b0, i_req.range_length};

    // Classify the command so the back end walks the table only for real table work.
    always_comb begin
        o_job.file_id        = i_req.file_id;
        o_job.owner_id       = i_req.owner_id;
        o_job.range_offset   = i_req.range_offset;
        o_job.range_length   = i_req.range_length;
        o_job.range_end      = sum[63:0];
        o_job.want_exclusive = i_req.want_exclusive;
        unique case (i_req.cmd)
            CMD_LOCK: begin
                o_job.op = (sum[64] && (sum[63:0] != 64'd0)) ? OP_WRAP : OP_LOCK;
            end
            CMD_UNLOCK:  o_job.op = OP_UNLOCK;
            CMD_RELEASE: o_job.op = OP_RELEASE;
            default:     o_job.op = OP_NOP;
        endcase
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;
endmodule
`default_nettype wire

### sv/brl_queue.sv
`default_nettype none
module brl_queue
    import brl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);
    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_slot[r_rp];

    // Two-entry circular buffer between the front and back ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

### sv/brl_back.sv
`default_nettype none
module brl_back
    import brl_pkg::*;
#(
    parameter int LOCK_SLOTS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_job  i_job,
    output logic       o_pop,
    brl_rsp_if.source  o_rsp
);
    localparam int IW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam logic [IW:0]   SLOTS_C = (IW + 1)'(LOCK_SLOTS);
    localparam logic [IW-1:0] LAST_C  = IW'(LOCK_SLOTS - 1);
    localparam int SW = $bits(t_slot);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    t_job          r_job, n_job;
    logic [IW:0]   r_idx, n_idx;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_free_ok, n_free_ok;
    logic [IW-1:0] r_free, n_free;
    logic [2:0]    r_status, n_status;
    logic          r_out_vld, n_out_vld;
    logic [2:0]    r_out_st, n_out_st;

    logic          vld_we, vld_wdata, vld_q, rd_en, dat_we;
    logic [IW-1:0] vld_waddr;
    logic [SW-1:0] dat_q;
    t_slot         slot, new_slot;
    logic [63:0]   slot_end;
    logic          same_file, same_owner, meet;

    // Valid bits and entry payload live in separate memories.
    brl_ram #(.WIDTH(1), .DEPTH(LOCK_SLOTS)) u_vld_ram (
        .i_clk   (i_clk),
        .i_we    (vld_we),
        .i_waddr (vld_waddr),
        .i_wdata (vld_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (vld_q)
    );

    brl_ram #(.WIDTH(SW), .DEPTH(LOCK_SLOTS)) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (r_free),
        .i_wdata (new_slot),
        .i_re    (rd_en),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (dat_q)
    );

    assign slot = t_slot'(dat_q);

    always_comb begin
        new_slot.file_id      = r_job.file_id;
        new_slot.owner_id     = r_job.owner_id;
        new_slot.range_offset = r_job.range_offset;
        new_slot.range_length = r_job.range_length;
        new_slot.exclusive    = r_job.want_exclusive;
    end

    // Compare the entry read back against the current request.
    assign slot_end   = slot.range_offset + slot.range_length;
    assign same_file  = vld_q && (slot.file_id == r_job.file_id);
    assign same_owner = same_file && (slot.owner_id == r_job.owner_id);
    assign meet = (r_job.range_length != 64'd0) && (slot.range_length != 64'd0) &&
                  ((r_job.range_end == 64'd0) || (slot.range_offset < r_job.range_end)) &&
                  ((slot_end == 64'd0) || (r_job.range_offset < slot_end));

    // Sequencer: clearing pass, then one slot compared per cycle per request.
    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_idx     = r_idx;
        n_pv      = 1'b0;
        n_pidx    = r_idx[IW-1:0];
        n_free_ok = r_free_ok;
        n_free    = r_free;
        n_status  = r_status;
        n_out_vld = r_out_vld && !o_rsp.ready;
        n_out_st  = r_out_st;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        vld_we    = 1'b0;
        vld_waddr = r_pidx;
        vld_wdata = 1'b0;
        dat_we    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                vld_we    = 1'b1;
                vld_waddr = r_idx[IW-1:0];
                n_idx     = r_idx + 1'b1;
                if (r_idx[IW-1:0] == LAST_C) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_job     = i_job;
                    n_idx     = '0;
                    n_free_ok = 1'b0;
                    n_status  = (i_job.op == OP_WRAP) ? ST_WRAP : ST_OK;
                    if ((i_job.op == OP_WRAP) || (i_job.op == OP_NOP)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx < SLOTS_C) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_pv  = 1'b1;
                end
                if (r_pv) begin
                    case (r_job.op)
                        OP_LOCK: begin
                            if (!vld_q && !r_free_ok) begin
                                n_free_ok = 1'b1;
                                n_free    = r_pidx;
                            end
                            if (same_file && meet && (r_job.want_exclusive || slot.exclusive))
                            begin
                                n_status = ST_CONFLICT;
                                n_state  = S_DONE;
                            end else if (r_pidx == LAST_C) begin
                                n_state = S_DONE;
                                if (r_free_ok || !vld_q) begin
                                    n_status = ST_OK;
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end
                        end
                        OP_UNLOCK: begin
                            if (same_owner && (slot.range_offset == r_job.range_offset) &&
                                (slot.range_length == r_job.range_length)) begin
                                vld_we   = 1'b1;
                                n_status = ST_OK;
                                n_state  = S_DONE;
                            end else if (r_pidx == LAST_C) begin
                                n_status = ST_NOT_LOCKED;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            vld_we = same_owner;
                            if (r_pidx == LAST_C) begin
                                n_status = ST_OK;
                                n_state  = S_DONE;
                            end
                        end
                    endcase
                    if (n_state == S_DONE) begin
                        n_pv = 1'b0;
                    end
                end
            end
            default: begin
                // Commit a granted lock, then hand the status to the output register.
                if ((r_job.op == OP_LOCK) && (r_status == ST_OK) && r_free_ok) begin
                    dat_we    = 1'b1;
                    vld_we    = 1'b1;
                    vld_waddr = r_free;
                    vld_wdata = 1'b1;
                    n_free_ok = 1'b0;
                end
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_out_st  = r_status;
                    n_state   = S_IDLE;
                end
            end
        endcase
        // A free slot found on the last compare is recorded before commit.
        if ((r_state == S_SCAN) && (n_state == S_DONE) && r_pv && (r_job.op == OP_LOCK) &&
            !r_free_ok && !vld_q && (n_status == ST_OK)) begin
            n_free_ok = 1'b1;
            n_free    = r_pidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_free_ok <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pv      <= n_pv;
            r_free_ok <= n_free_ok;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_pidx   <= n_pidx;
        r_free   <= n_free;
        r_status <= n_status;
        r_out_st <= n_out_st;
    end

    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_st;
endmodule
`default_nettype wire

### sv/brl_checker.sv
`default_nettype none
`include "assert_macros.svh"
module brl_checker
    import brl_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [2:0] i_rsp_status
);
    logic rsp_stall;
    logic req_beat;

    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign req_beat  = i_req_valid && i_req_ready;

    // A stalled response beat keeps its status.
    `BRL_ASSERT(a_rsp_hold, i_clk, i_rst_n, rsp_stall |=> (i_rsp_valid && $stable(i_rsp_status)))
    // Only defined status codes are reported.
    `BRL_ASSERT(a_rsp_code, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_status <= ST_NOT_LOCKED))
    // Reset leaves no response pending.
    `BRL_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_rsp_valid)
    // No response can appear in the cycle right after a request beat taken in the first cycle out of reset.
    `BRL_ASSERT(a_no_instant, i_clk, i_rst_n, ($past(!i_rst_n) && req_beat) |=> !i_rsp_valid)
endmodule

bind byte_range_lock_table_unit brl_checker u_brl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status)
);
`default_nettype wire
